### hw/rtl/mlrr_pkg.sv
// Package for the multilevel round-robin scheduler.
// It holds the sizes, codes and the structs shared by the cells and the top level.
// It has no dependencies.
`timescale 1ns / 1ps
package mlrr_pkg;

  localparam int NUM_TASKS  = 16;
  localparam int NUM_LEVELS = 8;
  localparam int TASK_W     = $clog2(NUM_TASKS);
  localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CNT_W      = $clog2(NUM_TASKS + 1);
  localparam int SLICE_W    = 8;
  localparam logic [SLICE_W-1:0] INIT_SLICE = SLICE_W'(2);

  // Life state of one task slot.
  typedef enum logic [1:0] {
    TS_FREE   = 2'd0,
    TS_SLEEP  = 2'd1,
    TS_ACTIVE = 2'd2
  } tstate_t;

  // Event kinds.
  typedef enum logic [1:0] {
    K_RUN   = 2'd0,
    K_SLEEP = 2'd1,
    K_TIMER = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_IGNORED = 2'd1,
    STS_REFUSED = 2'd2
  } status_t;

  // Record handed from cell to cell along the chain.
  typedef struct packed {
    logic [TASK_W-1:0]  id;
    tstate_t            state;
    logic [LVL_W-1:0]   level;
    logic [TASK_W-1:0]  pos;
    logic [SLICE_W-1:0] slice;
  } tok_t;

  // Lookup broadcast to all cells: by slot number or by queue place.
  typedef struct packed {
    logic              by_pos;
    logic [TASK_W-1:0] id;
    logic [LVL_W-1:0]  level;
    logic [TASK_W-1:0] pos;
  } query_t;

  // Update broadcast to all cells for one cycle.
  typedef struct packed {
    logic               en;
    logic [TASK_W-1:0]  id;
    logic               set_state;
    tstate_t            state;
    logic               set_place;
    logic [LVL_W-1:0]   level;
    logic [TASK_W-1:0]  pos;
    logic               set_slice;
    logic [SLICE_W-1:0] slice;
    logic               shift;
    logic [LVL_W-1:0]   shift_level;
    logic [TASK_W-1:0]  shift_pos;
  } cmd_t;

endpackage

### hw/rtl/mlrr_cell.sv
// One task slot of the scheduler chain: state, level, queue place and slice.
// It passes the lookup record on to the next cell each cycle.
// Depends on mlrr_pkg.
`timescale 1ns / 1ps
module mlrr_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mlrr_pkg::TASK_W-1:0]     cell_id,
  input  mlrr_pkg::query_t                query,
  input  mlrr_pkg::cmd_t                  cmd,
  input  mlrr_pkg::tok_t                  tok_in,
  output mlrr_pkg::tok_t                  tok_out
);
  import mlrr_pkg::*;

  tstate_t            tstate;
  logic [LVL_W-1:0]   tlevel;
  logic [TASK_W-1:0]  tpos;
  logic [SLICE_W-1:0] tslice;
  logic               hit;

  // Does this slot answer the current lookup?
  always_comb begin
    if (query.by_pos) begin
      hit = (tstate == TS_ACTIVE) && (tlevel == query.level) && (tpos == query.pos);
    end else begin
      hit = (cell_id == query.id);
    end
  end

  // Chain stage: replace the passing record when this slot matches.
  always_ff @(posedge clk) begin
    if (hit) begin
      tok_out <= '{id: cell_id, state: tstate, level: tlevel, pos: tpos, slice: tslice};
    end else begin
      tok_out <= tok_in;
    end
  end

  // Slot state; the addressed slot takes the command, others close the gap.
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= (cell_id == '0) ? TS_ACTIVE : TS_FREE;
      tlevel <= '0;
      tpos   <= '0;
      tslice <= (cell_id == '0) ? INIT_SLICE : '0;
    end else if (cmd.en) begin
      if (cmd.id == cell_id) begin
        if (cmd.set_state) begin
          tstate <= cmd.state;
        end
        if (cmd.set_place) begin
          tlevel <= cmd.level;
          tpos   <= cmd.pos;
        end
        if (cmd.set_slice) begin
          tslice <= cmd.slice;
        end
      end else if (cmd.shift && tstate == TS_ACTIVE && tlevel == cmd.shift_level &&
                   tpos > cmd.shift_pos) begin
        tpos <= tpos - TASK_W'(1);
      end
    end
  end

endmodule

### hw/rtl/multilevel_round_robin_scheduler.sv
// Top level of the multilevel round-robin scheduler: event sequencer,
// per-level counts and cursors, and the chain of task cells.
// Depends on mlrr_pkg and mlrr_cell.
//
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | kind[1:0] task_id[5:2] level[9:6] priority_req[17:10]
//  m_*     | out | current_task[3:0] time_slice[11:4] switched[12] status[14:13]
//
// One event at a time. Each lookup walks the whole chain of task cells, one cell
// per cycle, so the chain length sets how long each event takes.
// After reset task 0 runs at level 0 with slice 2; no clearing pass is needed.
// A result waits in the output register; the next event is taken meanwhile,
// and its own result holds back until the register is free.
`timescale 1ns / 1ps
module multilevel_round_robin_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // kind, task_id, level, priority_req, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // current_task, time_slice, switched, status, zero pad
);
  import mlrr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DEQ, S_ENQ, S_TIMER, S_PICK, S_FIND, S_OUT
  } fsm_t;

  fsm_t               state;
  kind_t              kind_r;
  logic [TASK_W-1:0]  tid_r;
  logic [3:0]         lvl_r;
  logic [SLICE_W-1:0] prio_r;
  logic [TASK_W-1:0]  cnt;
  logic [CNT_W-1:0]   level_count [NUM_LEVELS];
  logic [TASK_W-1:0]  level_cursor [NUM_LEVELS];
  logic [LVL_W-1:0]   current_level;
  logic               recheck;
  logic [TASK_W-1:0]  running;
  status_t            status_r;
  logic               need_pick;
  logic               by_pos_r;
  logic               do_enq_r;
  logic [LVL_W-1:0]   lv_new_r;
  logic [TASK_W-1:0]  out_task;
  logic [SLICE_W-1:0] out_slice;
  logic               out_switched;
  status_t            out_status;

  tok_t               tok [NUM_TASKS+1];
  tok_t               tok_last;
  query_t             query;
  cmd_t               cmd;

  logic [LVL_W-1:0]   ix;
  logic [CNT_W-1:0]   cnt_ix;
  logic [TASK_W-1:0]  cur_ix;
  logic [CNT_W-1:0]   total;
  logic [LVL_W-1:0]   pick_lv;
  logic [2:0]         lraw;
  logic [LVL_W-1:0]   lv_new_c;
  logic               is_active;
  logic               move;
  logic               deq_c;
  logic [CNT_W-1:0]   n_dec;
  logic [TASK_W-1:0]  c_shift;
  logic [TASK_W-1:0]  c_deq;
  logic [CNT_W-1:0]   c_inc;
  logic [TASK_W-1:0]  c_adv;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {1'b0, out_status, out_switched, out_slice, out_task};
  assign tok_last = tok[NUM_TASKS];
  assign tok[0]   = '0;

  // Chain of task cells.
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    mlrr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (TASK_W'(i)),
      .query   (query),
      .cmd     (cmd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Single level index used by the current step.
  always_comb begin
    unique case (state)
      S_DEQ:   ix = tok_last.level;
      S_ENQ:   ix = lv_new_r;
      default: ix = current_level;
    endcase
  end
  assign cnt_ix = level_count[ix];
  assign cur_ix = level_cursor[ix];

  // Active total and the lowest-numbered non-empty level, over fixed entries.
  always_comb begin
    total   = '0;
    pick_lv = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      total = total + level_count[i];
    end
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (level_count[i] != '0) begin
        pick_lv = LVL_W'(i);
      end
    end
  end

  // Decisions taken once the addressed slot has been looked up.
  always_comb begin
    lraw      = lvl_r[2:0];
    lv_new_c  = lvl_r[3] ? tok_last.level :
                (lraw > 3'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(lraw);
    is_active = (tok_last.state == TS_ACTIVE);
    move      = is_active && (tok_last.level != lv_new_c);
    deq_c     = (kind_r == K_RUN && move) ||
                (kind_r == K_SLEEP && is_active && total > CNT_W'(1));
    n_dec     = cnt_ix - CNT_W'(1);
    c_shift   = (tok_last.pos < cur_ix) ? cur_ix - TASK_W'(1) : cur_ix;
    c_deq     = ({1'b0, c_shift} >= n_dec) ? '0 : c_shift;
    c_inc     = {1'b0, cur_ix} + CNT_W'(1);
    c_adv     = (c_inc >= cnt_ix) ? '0 : c_inc[TASK_W-1:0];
  end

  // Lookup broadcast: slot of the event, or the task that runs next.
  always_comb begin
    query = '0;
    if (state == S_LOOK) begin
      query.id = tid_r;
    end else begin
      query.by_pos = by_pos_r;
      query.id     = running;
      query.level  = current_level;
      query.pos    = cur_ix;
    end
  end

  // Update broadcast: removal with compaction, then insertion and slice.
  always_comb begin
    cmd = '0;
    if (state == S_DEQ && deq_c) begin
      cmd.en          = 1'b1;
      cmd.id          = tid_r;
      cmd.set_state   = 1'b1;
      cmd.state       = TS_SLEEP;
      cmd.shift       = 1'b1;
      cmd.shift_level = tok_last.level;
      cmd.shift_pos   = tok_last.pos;
    end else if (state == S_ENQ && kind_r == K_RUN) begin
      cmd.en        = 1'b1;
      cmd.id        = tid_r;
      cmd.set_state = do_enq_r;
      cmd.state     = TS_ACTIVE;
      cmd.set_place = do_enq_r;
      cmd.level     = lv_new_r;
      cmd.pos       = cnt_ix[TASK_W-1:0];
      cmd.set_slice = (prio_r != '0);
      cmd.slice     = prio_r;
    end
  end

  // Event sequencer, level bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      cnt           <= '0;
      current_level <= '0;
      recheck       <= 1'b0;
      running       <= '0;
      need_pick     <= 1'b0;
      by_pos_r      <= 1'b0;
      do_enq_r      <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_count[i]  <= (i == 0) ? CNT_W'(1) : '0;
        level_cursor[i] <= '0;
      end
    end else begin
      // The output stage reloads the register itself when it has a new beat.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r    <= kind_t'(s_tdata[1:0]);
            tid_r     <= s_tdata[5:2];
            lvl_r     <= s_tdata[9:6];
            prio_r    <= s_tdata[17:10];
            status_r  <= STS_DONE;
            need_pick <= 1'b0;
            by_pos_r  <= 1'b0;
            do_enq_r  <= 1'b0;
            cnt       <= '0;
            unique case (kind_t'(s_tdata[1:0]))
              K_RUN, K_SLEEP: state <= S_LOOK;
              K_TIMER:        state <= S_TIMER;
              default: begin
                status_r <= STS_IGNORED;
                state    <= S_PICK;
              end
            endcase
          end
        end
        S_LOOK: begin
          cnt <= cnt + TASK_W'(1);
          if (cnt == TASK_W'(NUM_TASKS - 1)) begin
            cnt   <= '0;
            state <= S_DEQ;
          end
        end
        S_DEQ: begin
          lv_new_r <= lv_new_c;
          do_enq_r <= (kind_r == K_RUN) && (!is_active || move);
          if (kind_r == K_SLEEP) begin
            if (!is_active) begin
              status_r <= STS_IGNORED;
            end else if (total <= CNT_W'(1)) begin
              status_r <= STS_REFUSED;
            end
          end
          if (deq_c) begin
            level_count[ix]  <= n_dec;
            level_cursor[ix] <= c_deq;
            if (kind_r == K_SLEEP && tid_r == running) begin
              need_pick <= 1'b1;
              by_pos_r  <= 1'b1;
            end
          end
          state <= S_ENQ;
        end
        S_ENQ: begin
          if (kind_r == K_RUN) begin
            recheck <= 1'b1;
            if (do_enq_r) begin
              level_count[ix] <= cnt_ix + CNT_W'(1);
            end
          end
          state <= S_PICK;
        end
        S_TIMER: begin
          if (cnt_ix != '0) begin
            level_cursor[ix] <= c_adv;
          end
          need_pick <= recheck || (cnt_ix == '0);
          by_pos_r  <= 1'b1;
          state     <= S_PICK;
        end
        S_PICK: begin
          if (need_pick) begin
            current_level <= pick_lv;
            recheck       <= 1'b0;
          end
          cnt   <= '0;
          state <= S_FIND;
        end
        S_FIND: begin
          cnt <= cnt + TASK_W'(1);
          if (cnt == TASK_W'(NUM_TASKS - 1)) begin
            cnt   <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid     <= 1'b1;
            out_task     <= tok_last.id;
            out_slice    <= tok_last.slice;
            out_switched <= (tok_last.id != running);
            out_status   <= status_r;
            running      <= tok_last.id;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // At least one task stays active; a move between levels empties the
  // tables only in S_ENQ, between removal and insertion.
  assert property (@(posedge clk) disable iff (rst) (state != S_ENQ) |-> (total != '0))
    else $error("no active task left");

  // A search by queue place targets a filled level within its queue.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && by_pos_r) |->
      (level_count[current_level] != '0 &&
       {1'b0, level_cursor[current_level]} < level_count[current_level]))
    else $error("cursor outside the queue of the chosen level");

endmodule

### tb/multilevel_round_robin_scheduler_checker.sv
// Checker for the multilevel round-robin scheduler: watches both stream channels,
// keeps its own copy of the task tables and compares every result beat.
// Depends on mlrr_pkg.
`timescale 1ns / 1ps
module multilevel_round_robin_scheduler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  import mlrr_pkg::*;

  // Result fields, highest bits first, so that the lowest bits hold the task.
  typedef struct packed {
    logic [1:0] sts;
    logic       sw;
    logic [7:0] slice;
    logic [3:0] cur;
  } sched_res_t;

  tstate_t    st_tab [NUM_TASKS];
  int         lvl_tab [NUM_TASKS];
  logic [7:0] slice_tab [NUM_TASKS];
  int         queue_tab [NUM_LEVELS][NUM_TASKS];
  int         qcount [NUM_LEVELS];
  int         qcursor [NUM_LEVELS];
  int         cur_lvl;
  bit         recheck;
  int         running;
  sched_res_t expected_results[$];

  // Appends a task to the tail of its level queue and marks it active.
  function automatic void add_to_level(int t);
    int lv;
    lv = lvl_tab[t];
    if (qcount[lv] < NUM_TASKS) begin
      queue_tab[lv][qcount[lv]] = t;
      qcount[lv]++;
    end
    st_tab[t] = TS_ACTIVE;
  endfunction

  // Unqueues a task, closes the gap and keeps the cursor on its task if that stays.
  function automatic void remove_from_level(int t);
    int lv;
    int i;
    lv = lvl_tab[t];
    st_tab[t] = TS_SLEEP;
    for (i = 0; i < qcount[lv]; i++)
      if (queue_tab[lv][i] == t) break;
    if (i < qcount[lv]) begin
      qcount[lv]--;
      if (i < qcursor[lv]) qcursor[lv]--;
      if (qcursor[lv] >= qcount[lv]) qcursor[lv] = 0;
      for (; i < qcount[lv]; i++) queue_tab[lv][i] = queue_tab[lv][i+1];
    end
  endfunction

  function automatic void choose_level();
    int i;
    for (i = 0; i < NUM_LEVELS; i++)
      if (qcount[i] > 0) break;
    cur_lvl = (i < NUM_LEVELS) ? i : 0;
    recheck = 0;
  endfunction

  function automatic void reset_schedule();
    for (int i = 0; i < NUM_TASKS; i++) begin
      st_tab[i] = TS_FREE;
      lvl_tab[i] = 0;
      slice_tab[i] = '0;
    end
    for (int i = 0; i < NUM_LEVELS; i++) begin
      qcount[i] = 0;
      qcursor[i] = 0;
      for (int j = 0; j < NUM_TASKS; j++) queue_tab[i][j] = 0;
    end
    slice_tab[0] = INIT_SLICE;
    add_to_level(0);
    cur_lvl = 0;
    recheck = 0;
    running = 0;
  endfunction

  // Applies one event beat and returns the result it should produce.
  function automatic sched_res_t schedule_event(logic [23:0] d);
    kind_t      k;
    int         t;
    logic [3:0] lraw;
    logic [7:0] sl;
    int         lv;
    int         n;
    int         prev;
    int         total;
    sched_res_t r;
    k = kind_t'(d[1:0]);
    t = d[5:2];
    lraw = d[9:6];
    sl = d[17:10];
    prev = running;
    r.sts = STS_DONE;
    case (k)
      K_RUN: begin
        if (lraw[3]) lv = lvl_tab[t];
        else lv = (lraw > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : lraw;
        if (sl != 0) slice_tab[t] = sl;
        if (st_tab[t] == TS_ACTIVE && lvl_tab[t] != lv) remove_from_level(t);
        if (st_tab[t] != TS_ACTIVE) begin
          lvl_tab[t] = lv;
          add_to_level(t);
        end
        recheck = 1;
      end
      K_SLEEP: begin
        total = 0;
        for (int i = 0; i < NUM_LEVELS; i++) total += qcount[i];
        if (st_tab[t] != TS_ACTIVE) r.sts = STS_IGNORED;
        else if (total <= 1) r.sts = STS_REFUSED;
        else begin
          remove_from_level(t);
          if (t == running) begin
            choose_level();
            running = queue_tab[cur_lvl][qcursor[cur_lvl]];
          end
        end
      end
      K_TIMER: begin
        n = qcount[cur_lvl];
        if (n > 0) qcursor[cur_lvl] = (qcursor[cur_lvl] + 1 >= n) ? 0 : qcursor[cur_lvl] + 1;
        if (recheck || n == 0) choose_level();
        running = queue_tab[cur_lvl][qcursor[cur_lvl]];
      end
      default: r.sts = STS_IGNORED;
    endcase
    r.cur = 4'(running);
    r.slice = slice_tab[running];
    r.sw = (running != prev);
    return r;
  endfunction

  // Predict on each accepted event beat and compare each accepted result beat.
  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t exp_r;
    if (rst) begin
      reset_schedule();
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[14:0];
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || m_tdata[15] !== 1'b0) begin
            $display("%0t: mismatch: expected task %0d slice %0d sw %0d sts %0d,",
                     $time, exp_r.cur, exp_r.slice, exp_r.sw, exp_r.sts);
            $display("%0t:           got task %0d slice %0d sw %0d sts %0d",
                     $time, got.cur, got.slice, got.sw, got.sts);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) expected_results.push_back(schedule_event(s_tdata));
      pending <= expected_results.size();
    end
  end

endmodule

### tb/multilevel_round_robin_scheduler_test.sv
// Top of the scheduler testbench: clock, reset, event stimulus and verdict.
// Depends on mlrr_pkg, the scheduler and its checker.
`timescale 1ns / 1ps
module multilevel_round_robin_scheduler_test;
  import mlrr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  int          fail_count;
  int          pending;
  int          result_count;
  int          event_count = 0;
  int          sleep_count = 0;
  int          timer_count = 0;
  bit          stim_done = 1'b0;
  bit          stall_free = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multilevel_round_robin_scheduler i_dut (.*);

  multilevel_round_robin_scheduler_checker i_checker (.*);

  function automatic int gap_len();
    if ($urandom_range(9) < 7) return $urandom_range(2);
    return $urandom_range(40, 5);
  endfunction

  // Drives one event beat and holds it until the block takes it.
  // The beat is released at a falling edge; the next waits a gap unless stall-free.
  task automatic send_event(kind_t k, logic [3:0] t, logic [3:0] lv, logic [7:0] sl);
    int g;
    g = stall_free ? 0 : gap_len();
    repeat (g + 1) @(negedge clk);
    s_tdata <= {6'd0, sl, lv, t, k};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 1'b0;
    event_count++;
    if (k == K_SLEEP) sleep_count++;
    if (k == K_TIMER) timer_count++;
  endtask

  // Random result-side stalls, with stall-free stretches.
  initial begin
    @(negedge clk);
    forever begin
      if (!stall_free && $urandom_range(30) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(60, 10)) @(negedge clk);
      end else begin
        if (stall_free) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(3) != 0);
        @(negedge clk);
      end
    end
  end

  initial begin
    #60ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: extremes, every kind and the named corner cases.
    send_event(K_SLEEP, 4'd0, 4'd0, 8'd0);       // last active task refused
    send_event(K_SLEEP, 4'd5, 4'd0, 8'd0);       // sleep of a free task
    send_event(K_TIMER, 4'd0, 4'd0, 8'd0);
    send_event(K_NONE, 4'hf, 4'hf, 8'hff);
    send_event(K_RUN, 4'd15, 4'd15, 8'd255);     // free task woken at its kept level
    send_event(K_RUN, 4'd1, 4'd0, 8'd1);
    send_event(K_RUN, 4'd2, 4'hf, 8'd0);         // keep level and slice
    send_event(K_RUN, 4'd0, 4'd3, 8'd9);         // running task moves level
    send_event(K_TIMER, 4'd0, 4'd0, 8'd0);
    send_event(K_TIMER, 4'd0, 4'd0, 8'd0);
    send_event(K_RUN, 4'd3, 4'd7, 8'd170);
    send_event(K_RUN, 4'd4, 4'd0, 8'd85);
    send_event(K_TIMER, 4'd0, 4'd0, 8'd0);
    send_event(K_SLEEP, 4'd1, 4'd0, 8'd0);
    send_event(K_SLEEP, 4'd1, 4'd0, 8'd0);       // already sleeping
    send_event(K_TIMER, 4'd0, 4'd0, 8'd0);
    send_event(K_SLEEP, 4'd4, 4'd0, 8'd0);
    send_event(K_SLEEP, 4'd2, 4'd0, 8'd0);
    send_event(K_TIMER, 4'd0, 4'd0, 8'd0);
    send_event(K_RUN, 4'd1, 4'd8, 8'd0);
    // Wait until every result is back before random traffic.
    while (pending != 0) @(negedge clk);
    // Random: mostly runs, sleeps and timers on a busy task table.
    for (int i = 0; i < 800; i++) begin
      if (i == 400) stall_free = 1'b1;
      if (i == 500) stall_free = 1'b0;
      r = $urandom_range(99);
      if (r < 35) send_event(K_RUN, 4'($urandom),
                             ($urandom_range(3) == 0) ? 4'hf : 4'($urandom),
                             ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
      else if (r < 65) send_event(K_SLEEP, 4'($urandom), 4'($urandom), 8'($urandom));
      else if (r < 97) send_event(K_TIMER, 4'($urandom), 4'($urandom), 8'($urandom));
      else send_event(K_NONE, 4'($urandom), 4'($urandom), 8'($urandom));
    end
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Covered %0d events (%0d sleeps, %0d timer switches), %0d results checked.",
             event_count, sleep_count, timer_count, result_count);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mlrr_pkg.sv
hw/rtl/mlrr_cell.sv
hw/rtl/multilevel_round_robin_scheduler.sv
tb/multilevel_round_robin_scheduler_checker.sv
tb/multilevel_round_robin_scheduler_test.sv
